@@ rtl/ddrp_pkg.sv @@
// Package for the delimited decimal record parser.
// Holds constants, code enums and the byte-class token type; no dependencies.
package ddrp_pkg;

    // Field and value limits
    localparam int MAX_FIELD_CHARS = 31;
    localparam int VALUE_BITS      = 32;
    localparam int NUM_FIELDS      = 8;
    localparam int CHAR_CNT_BITS   = 5;
    localparam int FIELD_IDX_BITS  = 3;
    localparam int STATUS_BITS     = 2;

    // Output beat layout: status, then eight values, padded to whole bytes
    localparam int OUT_RAW_BITS  = STATUS_BITS + NUM_FIELDS * VALUE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_RAW_BITS;

    // Token queue between the front and back parts
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    // Fixed byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Configuration register indexes and reset values
    localparam logic CFG_DELIMITER = 1'b0;
    localparam logic CFG_COMMENT   = 1'b1;
    localparam logic [7:0] DELIMITER_RESET = 8'h3B;
    localparam logic [7:0] COMMENT_RESET   = 8'h23;

    // Record status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_LONG  = 2'd1,
        ST_SHORT = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // Line phase
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_FIELDS = 2'd1,
        PH_IGNORE = 2'd2
    } t_line_phase;

    // Number phase inside one field
    typedef enum logic [1:0] {
        NP_BEFORE = 2'd0,
        NP_DIGITS = 2'd1,
        NP_AFTER  = 2'd2
    } t_num_phase;

    // Classified input byte
    typedef struct packed {
        logic       flush;
        logic       is_ws;      // space or tab
        logic       is_cr;
        logic       is_lf;
        logic       is_nul;
        logic       is_comment;
        logic       is_delim;
        logic       is_digit;
        logic [3:0] digit;
    } t_token;

endpackage

@@ rtl/ddrp_front.sv @@
// Front part of the record parser: configuration registers and byte classifier.
// Depends on ddrp_pkg.
module ddrp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // configuration write channel
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    // input byte stream
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_flush,
    // to token queue
    input  logic            i_queue_full,
    output logic            o_push,
    output ddrp_pkg::t_token o_token
);

    logic [7:0] r_delim;
    logic [7:0] r_comment;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim   <= ddrp_pkg::DELIMITER_RESET;
            r_comment <= ddrp_pkg::COMMENT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ddrp_pkg::CFG_DELIMITER: r_delim   <= i_cfg_data;
                ddrp_pkg::CFG_COMMENT:   r_comment <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept a beat whenever the queue has room
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Byte classification
    always_comb begin
        o_token.flush      = i_flush;
        o_token.is_ws      = (i_byte == ddrp_pkg::CH_SPACE) || (i_byte == ddrp_pkg::CH_TAB);
        o_token.is_cr      = (i_byte == ddrp_pkg::CH_CR);
        o_token.is_lf      = (i_byte == ddrp_pkg::CH_LF);
        o_token.is_nul     = (i_byte == ddrp_pkg::CH_NUL);
        o_token.is_comment = (i_byte == r_comment);
        o_token.is_delim   = (i_byte == r_delim);
        o_token.is_digit   = (i_byte >= ddrp_pkg::CH_ZERO) && (i_byte <= ddrp_pkg::CH_NINE);
        o_token.digit      = i_byte[3:0];
    end

endmodule

@@ rtl/ddrp_queue.sv @@
// Short token queue that decouples the classifier from the line engine.
// Depends on ddrp_pkg.
module ddrp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ddrp_pkg::t_token i_token,
    output logic             o_full,
    output logic             o_valid,
    output ddrp_pkg::t_token o_token,
    input  logic             i_pop
);

    ddrp_pkg::t_token r_mem [ddrp_pkg::QUEUE_DEPTH];
    logic [ddrp_pkg::QUEUE_PTR_BITS-1:0] r_head;
    logic [ddrp_pkg::QUEUE_CNT_BITS-1:0] r_count;
    logic [ddrp_pkg::QUEUE_PTR_BITS-1:0] tail;
    logic do_pop;

    assign o_full  = (r_count == ddrp_pkg::QUEUE_CNT_BITS'(ddrp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_head];
    assign do_pop  = i_pop && o_valid;
    assign tail    = r_head + r_count[ddrp_pkg::QUEUE_PTR_BITS-1:0];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_token;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (do_pop) begin
                r_head <= r_head + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/ddrp_back.sv @@
// Back part of the record parser: line state machine, field values, output register.
// Depends on ddrp_pkg.
module ddrp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // from token queue
    input  logic                                i_valid,
    input  ddrp_pkg::t_token                    i_token,
    output logic                                o_pop,
    // record stream
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ddrp_pkg::OUT_DATA_BITS-1:0]  o_data
);

    localparam int VB = ddrp_pkg::VALUE_BITS;
    localparam int NSTORE = ddrp_pkg::NUM_FIELDS - 1;

    ddrp_pkg::t_line_phase r_phase, n_phase;
    ddrp_pkg::t_num_phase  r_nphase, n_nphase;
    logic [ddrp_pkg::FIELD_IDX_BITS-1:0] r_fidx, n_fidx;
    logic [ddrp_pkg::CHAR_CNT_BITS-1:0]  r_chars, n_chars;
    logic [VB-1:0]                       r_acc, n_acc;
    logic                                r_bad, n_bad;

    // Fields 0..6 are kept here; field 7 is still in the accumulator at line end
    logic [VB-1:0] r_store [NSTORE];

    logic                   r_out_valid;
    ddrp_pkg::t_status      r_out_status;
    logic [VB-1:0]          r_out_vals [ddrp_pkg::NUM_FIELDS];

    logic                   emit;
    ddrp_pkg::t_status      emit_status;
    logic                   store_we;
    logic                   stall;
    logic                   step;
    logic [VB-1:0]          acc_x10;

    assign acc_x10 = {r_acc[VB-4:0], 3'b000} + {r_acc[VB-2:0], 1'b0};

    // Next state and record decision for the token at the queue head
    always_comb begin
        logic                                in_fields;
        logic [ddrp_pkg::FIELD_IDX_BITS-1:0] fi;
        logic [ddrp_pkg::CHAR_CNT_BITS-1:0]  cc;
        ddrp_pkg::t_num_phase                np;
        logic [VB-1:0]                       acc;
        logic                                bad;
        logic                                end_line;
        logic                                last_field;

        n_phase     = r_phase;
        n_nphase    = r_nphase;
        n_fidx      = r_fidx;
        n_chars     = r_chars;
        n_acc       = r_acc;
        n_bad       = r_bad;
        emit        = 1'b0;
        emit_status = ddrp_pkg::ST_OK;
        store_we    = 1'b0;
        in_fields   = 1'b0;
        end_line    = 1'b0;
        fi          = r_fidx;
        cc          = r_chars;
        np          = r_nphase;
        acc         = r_acc;
        bad         = r_bad;
        last_field  = (r_fidx == ddrp_pkg::FIELD_IDX_BITS'(ddrp_pkg::NUM_FIELDS - 1));

        if (i_token.flush) begin
            end_line = (r_phase == ddrp_pkg::PH_FIELDS);
            n_phase  = ddrp_pkg::PH_START;
        end else begin
            case (r_phase)
                ddrp_pkg::PH_IGNORE: begin
                    if (i_token.is_lf) begin
                        n_phase = ddrp_pkg::PH_START;
                    end
                end
                ddrp_pkg::PH_START: begin
                    if (i_token.is_ws || i_token.is_cr || i_token.is_lf) begin
                        n_phase = ddrp_pkg::PH_START;
                    end else if (i_token.is_nul || i_token.is_comment) begin
                        n_phase = ddrp_pkg::PH_IGNORE;
                    end else begin
                        // fresh line, then the byte is taken as a field byte
                        in_fields  = 1'b1;
                        n_phase    = ddrp_pkg::PH_FIELDS;
                        fi         = '0;
                        cc         = '0;
                        np         = ddrp_pkg::NP_BEFORE;
                        acc        = '0;
                        bad        = 1'b0;
                        last_field = 1'b0;
                    end
                end
                ddrp_pkg::PH_FIELDS: in_fields = 1'b1;
                default: n_phase = ddrp_pkg::PH_START;
            endcase
        end

        n_fidx   = fi;
        n_chars  = cc;
        n_nphase = np;
        n_acc    = acc;
        n_bad    = bad;

        if (in_fields) begin
            if (i_token.is_delim && !i_token.is_nul && !i_token.is_lf && !i_token.is_cr) begin
                // close field
                n_bad    = bad || (np == ddrp_pkg::NP_BEFORE);
                n_chars  = '0;
                n_nphase = ddrp_pkg::NP_BEFORE;
                n_acc    = '0;
                if (last_field) begin
                    emit        = 1'b1;
                    emit_status = ddrp_pkg::ST_LONG;
                    n_phase     = ddrp_pkg::PH_IGNORE;
                end else begin
                    store_we = 1'b1;
                    n_fidx   = fi + 1'b1;
                end
            end else if (i_token.is_nul || i_token.is_lf || i_token.is_cr) begin
                end_line = 1'b1;
                n_phase  = i_token.is_lf ? ddrp_pkg::PH_START : ddrp_pkg::PH_IGNORE;
            end else if (cc >= ddrp_pkg::CHAR_CNT_BITS'(ddrp_pkg::MAX_FIELD_CHARS)) begin
                // line abandoned; the accumulator must be clear for the next line
                emit        = 1'b1;
                emit_status = ddrp_pkg::ST_LONG;
                n_phase     = ddrp_pkg::PH_IGNORE;
                n_acc       = '0;
            end else begin
                n_chars = cc + 1'b1;
                if (i_token.is_digit) begin
                    if (np == ddrp_pkg::NP_AFTER) begin
                        n_bad = 1'b1;
                    end else begin
                        n_nphase = ddrp_pkg::NP_DIGITS;
                        n_acc    = acc_x10 + VB'(i_token.digit);
                    end
                end else if (i_token.is_ws) begin
                    if (np == ddrp_pkg::NP_DIGITS) begin
                        n_nphase = ddrp_pkg::NP_AFTER;
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end
        end

        // End of line: record with status from field count and number checks
        if (end_line) begin
            emit = 1'b1;
            if (!last_field) begin
                emit_status = ddrp_pkg::ST_SHORT;
            end else if (bad || (np == ddrp_pkg::NP_BEFORE)) begin
                emit_status = ddrp_pkg::ST_BAD;
            end else begin
                emit_status = ddrp_pkg::ST_OK;
            end
        end

        // A line end or a flush clears the per-line counters
        if (i_token.flush || end_line) begin
            n_fidx   = '0;
            n_chars  = '0;
            n_nphase = ddrp_pkg::NP_BEFORE;
            n_acc    = '0;
            n_bad    = 1'b0;
        end
    end

    // Hold the head token only when it makes a record and the output is blocked
    assign stall = emit && r_out_valid && !i_ready;
    assign step  = i_valid && !stall;
    assign o_pop = step;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ddrp_pkg::PH_START;
            r_nphase <= ddrp_pkg::NP_BEFORE;
            r_fidx   <= '0;
            r_chars  <= '0;
            r_acc    <= '0;
            r_bad    <= 1'b0;
        end else if (step) begin
            r_phase  <= n_phase;
            r_nphase <= n_nphase;
            r_fidx   <= n_fidx;
            r_chars  <= n_chars;
            r_acc    <= n_acc;
            r_bad    <= n_bad;
        end
    end

    // Finished field values
    always_ff @(posedge i_clk) begin
        if (step && store_we) begin
            r_store[r_phase == ddrp_pkg::PH_FIELDS ? r_fidx : '0] <= r_acc;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_status <= emit_status;
            for (int k = 0; k < NSTORE; k++) begin
                r_out_vals[k] <= (emit_status == ddrp_pkg::ST_OK) ? r_store[k] : '0;
            end
            r_out_vals[NSTORE] <= (emit_status == ddrp_pkg::ST_OK) ? r_acc : '0;
        end
    end

    // Pack the record beat: status lowest, then value_0 .. value_7
    always_comb begin
        o_data = '0;
        o_data[ddrp_pkg::STATUS_BITS-1:0] = r_out_status;
        for (int k = 0; k < ddrp_pkg::NUM_FIELDS; k++) begin
            o_data[ddrp_pkg::STATUS_BITS + k*VB +: VB] = r_out_vals[k];
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ rtl/delimited_decimal_record_parser_unit.sv @@
// Delimited decimal record parser, top level. Takes one text byte per cycle unless stalled.
// A record is loaded into the output register when its last token leaves the queue.
// Throughput: one byte per cycle, set by the one-token-per-cycle engine, barring stalls.
// Reset (i_rst_n, synchronous, active low) clears all control state and sets
// the delimiter to ';' and the comment character to '#'.
// Depends on ddrp_pkg, ddrp_front, ddrp_queue and ddrp_back.
module delimited_decimal_record_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    // text stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] text_byte
    input  logic                                i_s_axis_tuser,  // [0] flush
    // record stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] status, [33:2] value_0, ... [257:226] value_7, [263:258] zero
    output logic [ddrp_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata
);

    ddrp_pkg::t_token push_token;
    ddrp_pkg::t_token head_token;
    logic push;
    logic queue_full;
    logic queue_valid;
    logic pop;

    ddrp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_flush      (i_s_axis_tuser),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_token      (push_token)
    );

    ddrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_token (head_token),
        .i_pop   (pop)
    );

    ddrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_token (head_token),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

@@ tb/ddrp_record_check.sv @@
// Record checker for the delimited decimal record parser testbench.
// Watches the config, text and record channels, predicts each record and compares it.
// Depends on ddrp_pkg for widths, byte codes and status and phase enums.
`timescale 1ns / 100ps

module delimited_decimal_record_parser_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config channel
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    // text channel
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] text_byte
    input  logic                               i_s_tuser,   // [0] flush
    // record channel
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [ddrp_pkg::OUT_DATA_BITS-1:0] i_m_tdata,   // [1:0] status, then value_0..7
    // results for the test top
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_records
);
    import ddrp_pkg::*;

    typedef struct packed {
        t_status                                status;
        logic [NUM_FIELDS-1:0][VALUE_BITS-1:0]  value;
    } t_record;

    // Shadow configuration
    logic [7:0]            delim_ch;
    logic [7:0]            cmt_ch;

    // Shadow parser state
    t_line_phase           ln_phase;
    logic [3:0]            fld_idx;
    logic [4:0]            fld_chars;
    t_num_phase            num_ph;
    logic [VALUE_BITS-1:0] acc;
    logic [VALUE_BITS-1:0] fld_vals [NUM_FIELDS];
    t_status               ln_status;

    t_record               pending_records [$];
    int                    errors  = 0;
    int                    records = 0;

    function automatic void start_field();
        fld_chars = '0;
        num_ph    = NP_BEFORE;
        acc       = '0;
    endfunction

    function automatic void start_line();
        fld_idx   = '0;
        ln_status = ST_OK;
        start_field();
    endfunction

    // closes the open field; true while fewer than eight fields are done
    function automatic bit field_done();
        if (num_ph == NP_BEFORE) ln_status = ST_BAD;
        if (fld_idx < NUM_FIELDS) fld_vals[fld_idx[2:0]] = acc;
        if (fld_idx < 4'd15) fld_idx = fld_idx + 4'd1;
        start_field();
        return fld_idx < NUM_FIELDS;
    endfunction

    // values only travel with an ok record
    function automatic void push_record(input t_status st);
        t_record rec;
        int      j;
        rec.status = st;
        rec.value  = '0;
        if (st == ST_OK)
            for (j = 0; j < NUM_FIELDS; j++) rec.value[j] = fld_vals[j];
        pending_records.push_back(rec);
    endfunction

    function automatic void end_record();
        void'(field_done());
        if (fld_idx < NUM_FIELDS) push_record(ST_SHORT);
        else push_record(ln_status);
    endfunction

    // One accepted text beat
    task automatic parse_beat(input logic [7:0] b, input logic fl);
        if (fl) begin
            if (ln_phase == PH_FIELDS) end_record();
            ln_phase = PH_START;
            start_line();
            return;
        end
        if (ln_phase == PH_IGNORE) begin
            if (b == CH_LF) ln_phase = PH_START;
            return;
        end
        if (ln_phase == PH_START) begin
            if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) return;
            if (b == CH_NUL || b == cmt_ch) begin
                ln_phase = PH_IGNORE;
                return;
            end
            ln_phase = PH_FIELDS;
            start_line();
        end
        // line enders win over the delimiter, the delimiter over everything else
        if (b == CH_NUL || b == CH_LF || b == CH_CR) begin
            end_record();
            ln_phase = (b == CH_LF) ? PH_START : PH_IGNORE;
        end else if (b == delim_ch) begin
            if (!field_done()) begin
                ln_phase = PH_IGNORE;
                push_record(ST_LONG);
            end
        end else if (fld_chars >= MAX_FIELD_CHARS) begin
            ln_phase = PH_IGNORE;
            push_record(ST_LONG);
        end else begin
            fld_chars = fld_chars + 5'd1;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                if (num_ph == NP_AFTER) begin
                    ln_status = ST_BAD;
                end else begin
                    num_ph = NP_DIGITS;
                    acc    = acc * 10 + VALUE_BITS'(b - CH_ZERO);
                end
            end else if (b == CH_SPACE || b == CH_TAB) begin
                if (num_ph == NP_DIGITS) num_ph = NP_AFTER;
            end else begin
                ln_status = ST_BAD;
            end
        end
    endtask

    // One accepted record beat against the oldest prediction
    task automatic check_record(input logic [OUT_DATA_BITS-1:0] beat);
        t_record               want;
        logic [VALUE_BITS-1:0] got;
        int                    j;
        if (pending_records.size() == 0) begin
            errors++;
            $display("%0t: unexpected record: expected none, actual status %0d",
                     $time, beat[STATUS_BITS-1:0]);
            return;
        end
        want = pending_records.pop_front();
        records++;
        if (beat[STATUS_BITS-1:0] !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, beat[STATUS_BITS-1:0]);
        end
        for (j = 0; j < NUM_FIELDS; j++) begin
            got = beat[STATUS_BITS + j*VALUE_BITS +: VALUE_BITS];
            if (got !== want.value[j]) begin
                errors++;
                $display("%0t: value_%0d mismatch: expected %0d, actual %0d",
                         $time, j, want.value[j], got);
            end
        end
    endtask

    // Everything sampled on the edge, before the drivers update
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            delim_ch = DELIMITER_RESET;
            cmt_ch   = COMMENT_RESET;
            ln_phase = PH_START;
            foreach (fld_vals[k]) fld_vals[k] = '0;
            start_line();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DELIMITER) delim_ch = i_cfg_data;
                else cmt_ch = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) parse_beat(i_s_tdata, i_s_tuser);
            if (i_m_tvalid && i_m_tready) check_record(i_m_tdata);
        end
        o_errors  <= errors;
        o_pending <= pending_records.size();
        o_records <= records;
    end

endmodule

@@ tb/delimited_decimal_record_parser_unit_test.sv @@
// Test top for the delimited decimal record parser: clock, reset, text stimulus,
// config writes, record back-pressure and the verdict.
// Depends on ddrp_pkg, the parser top level and the record checker.
`timescale 1ns / 100ps

module delimited_decimal_record_parser_unit_test;
    import ddrp_pkg::*;

    localparam int SEG_BEATS    = 180;
    localparam int SEG_COUNT    = 6;
    localparam int HOLD_SEG     = 5;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // per segment: delimiter and comment char, segment 0 in the low byte
    localparam logic [SEG_COUNT-1:0][7:0] DELIM_SET =
        {8'h3B, 8'h20, 8'h00, 8'h35, 8'hFF, 8'h2C};
    localparam logic [SEG_COUNT-1:0][7:0] COMMENT_SET =
        {8'h23, 8'h37, 8'hFF, 8'h20, 8'h00, 8'h23};

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_index;
    logic [7:0]               cfg_data;
    logic                     txt_valid;
    logic                     txt_ready;
    logic [7:0]               txt_data;
    logic                     txt_flush;
    logic                     rec_valid;
    logic                     rec_ready;
    logic [OUT_DATA_BITS-1:0] rec_data;

    int chk_errors;
    int chk_pending;
    int chk_records;

    // stimulus bookkeeping
    int         src_idle = 18;
    int         snk_idle = 85;
    int         seg_no   = -1;
    int         beats    = 0;
    int         flushes  = 0;
    int         lines    = 0;
    int         settings = 0;
    int         cycle_cnt = 0;
    logic [7:0] delim_ch = DELIMITER_RESET;
    logic [7:0] cmt_ch   = COMMENT_RESET;
    logic [8:0] line_buf [$];   // {flush, byte}

    delimited_decimal_record_parser_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (txt_valid),
        .o_s_axis_tready (txt_ready),
        .i_s_axis_tdata  (txt_data),
        .i_s_axis_tuser  (txt_flush),
        .o_m_axis_tvalid (rec_valid),
        .i_m_axis_tready (rec_ready),
        .o_m_axis_tdata  (rec_data)
    );

    delimited_decimal_record_parser_check i_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (txt_valid),
        .i_s_tready  (txt_ready),
        .i_s_tdata   (txt_data),
        .i_s_tuser   (txt_flush),
        .i_m_tvalid  (rec_valid),
        .i_m_tready  (rec_ready),
        .i_m_tdata   (rec_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_records   (chk_records)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d records still due", cycle_cnt, chk_pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Record side: random back-pressure plus one long hold-off
    initial begin
        bit held;
        int n;
        held = 1'b0;
        rec_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (seg_no == HOLD_SEG && !held) begin
                held = 1'b1;
                rec_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
            end
            rec_ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // Text beat with random gaps in front of it
    task automatic send_beat(input logic [7:0] b, input logic fl);
        while ($urandom_range(99) < src_idle) begin
            txt_valid <= 1'b0;
            @(posedge clk);
        end
        txt_valid <= 1'b1;
        txt_data  <= b;
        txt_flush <= fl;
        @(posedge clk);
        while (!txt_ready) @(posedge clk);
        beats++;
        if (fl) flushes++;
    endtask

    task automatic send_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_beat(s[k], 1'b0);
        lines++;
    endtask

    task automatic send_flush();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    // Both registers, back to back
    task automatic write_settings(input logic [7:0] dl, input logic [7:0] cm);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= dl;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_COMMENT;
        cfg_data  <= cm;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        delim_ch = dl;
        cmt_ch   = cm;
        settings++;
    endtask

    // Stop sending, wait for every due record and let the pipe settle
    task automatic drain();
        txt_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pad_char();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] lead_char();
        int r;
        r = $urandom_range(2);
        return (r == 0) ? CH_SPACE : (r == 1) ? CH_TAB : CH_CR;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        line_buf.push_back({1'b0, b});
    endfunction

    function automatic void push_digit();
        push_byte(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    // Mostly short numbers, some that wrap, a few near the length limit
    function automatic void add_field(input bit broken);
        int how;
        int ndig;
        how  = $urandom_range(99);
        ndig = (how < 88) ? $urandom_range(1, 3) :
               (how < 98) ? $urandom_range(4, 12) : $urandom_range(29, 33);
        if ($urandom_range(4) == 0) push_byte(pad_char());
        if (broken) begin
            case ($urandom_range(3))
                0: push_byte($urandom_range(1) ? CH_MINUS : CH_PLUS);
                1: ndig = 0;
                2: begin
                    push_digit();
                    push_byte(pad_char());
                end
                default: push_byte(8'($urandom_range(255)));
            endcase
        end
        repeat (ndig) push_digit();
        if ($urandom_range(4) == 0) push_byte(pad_char());
    endfunction

    // One line: mostly eight-field records, some bad counts, comments, blanks, noise
    function automatic void build_line();
        int kind;
        int nfld;
        int term;
        int j;
        line_buf.delete();
        repeat ($urandom_range(2)) push_byte(lead_char());
        kind = $urandom_range(99);
        if (kind < 5) begin
            push_byte(cmt_ch);
            repeat ($urandom_range(6)) push_byte(8'($urandom_range(255)));
        end else if (kind < 9) begin
            // blank line
        end else if (kind < 13) begin
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
        end else begin
            nfld = (kind < 23) ? $urandom_range(1, 10) : 8;
            for (j = 0; j < nfld; j++) begin
                if (j != 0) push_byte(delim_ch);
                add_field($urandom_range(99) < 3);
            end
        end
        term = $urandom_range(99);
        if (term < 80) begin
            push_byte(CH_LF);
        end else if (term < 87) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
        end else if (term < 93) begin
            line_buf.push_back({1'b1, 8'($urandom_range(255))});
        end else begin
            push_byte(CH_NUL);
            push_byte(8'($urandom_range(255)));
            push_byte(CH_LF);
        end
    endfunction

    // Main stimulus
    initial begin
        int seg;
        int seg_beats;
        int k;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= '0;
        txt_valid <= 1'b0;
        txt_data  <= '0;
        txt_flush <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_settings(DELIMITER_RESET, COMMENT_RESET);

        // Directed lines under the default delimiter and comment char
        send_str("0;1;2;3;4;5;6;4294967295\n");
        send_str(" \t\015 9;8;7;6;5;4;3;4294967296\n");     // skipped lead-in, wrap to 0
        send_str("99999999999;1;1;1;1;1;1;1\n");            // wraps
        send_str("#;1;2;3;4;5;6;7\n");                       // comment line
        send_str("\n");
        send_str(" 1 ;\t2\t;3;4;5;6;7;8 ");
        send_flush();                                         // flush closes the record
        send_flush();                                         // flush at line start: nothing
        send_str("1;2;3\n");                                  // too few fields
        send_str("1;2;3;4;5;6;7;8;9\n");                      // ninth field
        send_str("-1;2;3;4;5;6;7;+8\n");                      // signs
        send_str("1 2;2;3;4;5;6;7;8\n");                      // digits split by a space
        send_str(";2;3;4;5;6;7;8\n");                         // empty field
        send_str("1;2;3;-4\n");                               // short wins over bad
        send_str("1;2;3;4;5;6;7;8\0159\n");                   // CR ends early
        send_str("1;2;3");
        send_beat(CH_NUL, 1'b0);                              // NUL ends early
        send_str("x;4\n");
        send_beat(CH_NUL, 1'b0);                              // NUL at line start
        send_str("1;2;3;4;5;6;7;8\n");
        send_str("#");
        send_flush();                                         // flush while ignoring
        repeat (30) send_beat(CH_ZERO, 1'b0);
        send_str("7;1;2;3;4;5;6;7\n");                        // field of exactly 31 chars
        repeat (32) send_beat(CH_ZERO, 1'b0);
        send_str(";1;2;3;4;5;6;7\n");                         // field too long

        // Random lines, one delimiter/comment setting per segment
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            drain();
            case (seg / 2)
                0: begin src_idle = 18; snk_idle = 85; end
                1: begin src_idle = 85; snk_idle = 18; end
                default: begin src_idle = 0; snk_idle = 0; end
            endcase
            write_settings(DELIM_SET[seg], COMMENT_SET[seg]);
            seg_no = seg;
            seg_beats = 0;
            while (seg_beats < SEG_BEATS) begin
                build_line();
                for (k = 0; k < line_buf.size(); k++)
                    send_beat(line_buf[k][7:0], line_buf[k][8]);
                seg_beats += line_buf.size();
                lines++;
            end
        end
        drain();

        $display("Sent %0d text beats (%0d flush) in %0d lines under %0d register settings.",
                 beats, flushes, lines, settings);
        $display("Checked %0d records, with a %0d-cycle record stall while text kept coming.",
                 chk_records, HOLD_CYCLES);
        if (chk_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ddrp_pkg.sv
rtl/ddrp_front.sv
rtl/ddrp_queue.sv
rtl/ddrp_back.sv
rtl/delimited_decimal_record_parser_unit.sv
tb/ddrp_record_check.sv
tb/delimited_decimal_record_parser_unit_test.sv
